// ----- hdl/seam_pkg.sv -----
// Shared types, constants and the helper function of the Sobel edge ASCII mapper.
// Used by every module of the block; it depends on nothing else.
package seam_pkg;

   localparam int MAX_WIDTH_DEF   = 1024;
   localparam int QUEUE_DEPTH_DEF = 4;
   localparam int MIN_WIDTH       = 3;
   localparam int ROW_CNT_W       = 17;
   localparam int CSR_ADDR_W      = 4;
   localparam int CSR_DATA_W      = 32;
   localparam int THR_SQ_W        = 22;

   localparam logic [10:0] IMAGE_WIDTH_RST    = 11'd640;
   localparam logic [15:0] IMAGE_HEIGHT_RST   = 16'd480;
   localparam logic [10:0] EDGE_THRESHOLD_RST = 11'd350;
   localparam logic        EDGES_ENABLED_RST  = 1'b1;

   localparam logic [18:0] GRAY_RECIP = 19'd683;
   localparam int          GRAY_SHIFT = 11;

   localparam logic [19:0] TAN_LO = 20'd106;
   localparam logic [19:0] TAN_HI = 20'd618;

   localparam logic [6:0] CHAR_VERT = 7'd124;
   localparam logic [6:0] CHAR_BACK = 7'd92;
   localparam logic [6:0] CHAR_FLAT = 7'd95;
   localparam logic [6:0] CHAR_FWD  = 7'd47;

   typedef enum logic [1:0] {
      REG_IMAGE_WIDTH,
      REG_IMAGE_HEIGHT,
      REG_EDGE_THRESHOLD,
      REG_EDGES_ENABLED
   } reg_index_type;

   typedef logic [7:0] pixel_type;
   typedef logic [2:0][2:0][7:0] window_type;

   typedef struct packed {
      logic                restart;
      logic [15:0]         h_last;
      logic [THR_SQ_W-1:0] thr2;
      logic                edges_en;
   } cfg_type;

   function automatic logic [6:0] lum_char(input logic [7:0] gray);
      logic [6:0] ch;
      case (gray) inside
         [8'd0:8'd28]:    ch = 7'd32;
         [8'd29:8'd56]:   ch = 7'd46;
         [8'd57:8'd84]:   ch = 7'd59;
         [8'd85:8'd113]:  ch = 7'd99;
         [8'd114:8'd141]: ch = 7'd111;
         [8'd142:8'd169]: ch = 7'd80;
         [8'd170:8'd198]: ch = 7'd79;
         [8'd199:8'd226]: ch = 7'd63;
         [8'd227:8'd254]: ch = 7'd64;
         [8'd255:8'd255]: ch = 7'd35;
         default:         ch = 7'd32;
      endcase
      return ch;
   endfunction

endpackage

// ----- hdl/seam_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Depends on seam_pkg for its default sizes.
module seam_ram #(
   parameter int WIDTH = $bits(seam_pkg::pixel_type),
   parameter int DEPTH = seam_pkg::MAX_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/seam_queue.sv -----
// Short first-in first-out queue of windows between the front and back parts.
// Depends on seam_pkg for its default sizes.
module seam_queue #(
   parameter int WIDTH = $bits(seam_pkg::window_type),
   parameter int DEPTH = seam_pkg::QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- hdl/seam_front.sv -----
// Front part: accepts pixel beats, tracks the input position, converts to grey,
// keeps the two line stores and the 3x3 window. Depends on seam_pkg and seam_ram.
module seam_front #(
   parameter int MAX_WIDTH = seam_pkg::MAX_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  seam_pkg::cfg_type            cfg,
   input  logic [$clog2(MAX_WIDTH)-1:0] w_last,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_op,
   input  logic [7:0]                   req_red,
   input  logic [7:0]                   req_green,
   input  logic [7:0]                   req_blue,
   output logic                         win_valid,
   input  logic                         win_ready,
   output seam_pkg::window_type         win_data
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = seam_pkg::ROW_CNT_W;

   logic [COL_W-1:0]     col_ff, col_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic                 s1_valid_ff, s1_valid_in;
   seam_pkg::pixel_type  s1_gray_ff;
   logic [COL_W-1:0]     s1_addr_ff;
   logic                 s1_c0_ff;
   logic                 s1_prod_ff;
   logic                 s1_upd_ff;
   seam_pkg::window_type win_ff, win_in;

   logic                 accept;
   logic                 take;
   logic                 s1_fire;
   logic                 in_frame;
   logic                 drop;
   logic                 col_zero;
   logic                 row_done;
   logic                 prod;
   logic [ROW_W-1:0]     row_last;
   logic [9:0]           rgb_sum;
   logic [18:0]          gray_prod;
   seam_pkg::pixel_type  gray;
   seam_pkg::pixel_type  up_rd;
   seam_pkg::pixel_type  lo_rd;
   seam_pkg::pixel_type  new_col [3];

   assign accept    = req_valid && req_ready;
   assign s1_fire   = s1_valid_ff && (!s1_prod_ff || win_ready);
   assign req_ready = !s1_valid_ff || s1_fire;

   assign row_last  = ROW_W'(cfg.h_last);
   assign in_frame  = row_ff <= row_last;
   assign drop      = req_op && in_frame;
   assign take      = accept && !drop;
   assign col_zero  = col_ff == '0;
   assign row_done  = col_zero && (row_ff >= row_last + ROW_W'(2));
   assign prod      = col_zero ? (row_ff >= ROW_W'(2)) : (row_ff != '0);

   assign rgb_sum   = 10'(req_red) + 10'(req_green) + 10'(req_blue);
   assign gray_prod = 19'(rgb_sum) * seam_pkg::GRAY_RECIP;
   assign gray      = (in_frame && !req_op) ? gray_prod[seam_pkg::GRAY_SHIFT +: 8] : '0;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (cfg.restart) begin
         col_in = '0;
         row_in = '0;
      end else if (take) begin
         if (row_done) begin
            col_in = '0;
            row_in = '0;
         end else if (col_ff == w_last) begin
            col_in = '0;
            row_in = row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (take) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_gray_ff <= gray;
         s1_addr_ff <= col_ff;
         s1_c0_ff   <= col_zero;
         s1_prod_ff <= prod;
         s1_upd_ff  <= !row_done;
      end
   end

   seam_ram #(
      .WIDTH ($bits(seam_pkg::pixel_type)),
      .DEPTH (MAX_WIDTH)
   ) u_upper_line (
      .clock   (clock),
      .wr_en   (s1_fire && s1_upd_ff),
      .wr_addr (s1_addr_ff),
      .wr_data (lo_rd),
      .rd_en   (take),
      .rd_addr (col_ff),
      .rd_data (up_rd)
   );

   seam_ram #(
      .WIDTH ($bits(seam_pkg::pixel_type)),
      .DEPTH (MAX_WIDTH)
   ) u_lower_line (
      .clock   (clock),
      .wr_en   (s1_fire && s1_upd_ff),
      .wr_addr (s1_addr_ff),
      .wr_data (s1_gray_ff),
      .rd_en   (take),
      .rd_addr (col_ff),
      .rd_data (lo_rd)
   );

   assign new_col[0] = up_rd;
   assign new_col[1] = lo_rd;
   assign new_col[2] = s1_gray_ff;

   always_comb begin
      win_in   = win_ff;
      win_data = '0;
      for (int i = 0; i < 3; i++) begin
         win_data[i][0] = win_ff[i][1];
         win_data[i][1] = win_ff[i][2];
         win_data[i][2] = s1_c0_ff ? 8'd0 : new_col[i];
         if (s1_fire && s1_upd_ff) begin
            win_in[i][0] = s1_c0_ff ? 8'd0 : win_ff[i][1];
            win_in[i][1] = s1_c0_ff ? 8'd0 : win_ff[i][2];
            win_in[i][2] = new_col[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

   assign win_valid = s1_valid_ff && s1_prod_ff;

endmodule

// ----- hdl/seam_back.sv -----
// Back part: Sobel gradients, magnitude test, direction sector and character
// choice, output position and the result register. Depends on seam_pkg.
module seam_back #(
   parameter int MAX_WIDTH = seam_pkg::MAX_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  seam_pkg::cfg_type            cfg,
   input  logic [$clog2(MAX_WIDTH)-1:0] w_last,
   input  logic                         win_valid,
   output logic                         win_ready,
   input  seam_pkg::window_type         win_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [6:0]                   rsp_out_char,
   output logic                         rsp_is_edge,
   output logic                         rsp_end_of_row,
   output logic                         rsp_end_of_frame
);

   localparam int COL_W = $clog2(MAX_WIDTH);

   logic [COL_W-1:0]     out_col_ff, out_col_in;
   logic [15:0]          out_row_ff, out_row_in;

   logic                 p1_valid_ff;
   logic signed [10:0]   p1_gx_ff, p1_gy_ff;
   logic [6:0]           p1_lum_ff;
   logic                 p1_eor_ff, p1_eof_ff;

   logic                 p2_valid_ff;
   logic [19:0]          p2_gx2_ff, p2_gy2_ff;
   logic [19:0]          p2_g256_ff, p2_t106_ff, p2_t618_ff;
   logic                 p2_neg_ff, p2_zero_ff;
   logic [6:0]           p2_lum_ff;
   logic                 p2_eor_ff, p2_eof_ff;

   logic                 rsp_valid_ff;
   logic [6:0]           rsp_char_ff;
   logic                 rsp_edge_ff, rsp_eor_ff, rsp_eof_ff;

   logic                 out_free, p2_free, p1_free, pop;
   seam_pkg::window_type k;
   logic [11:0]          gx_pos, gx_neg, gy_pos, gy_neg, gx_w, gy_w;
   logic signed [10:0]   gx_in, gy_in;
   logic                 eor, eof;

   logic                 flip;
   logic signed [11:0]   gx_ext, gy_ext, gx_n, gy_n, ax_w;
   logic signed [21:0]   gx_sq, gy_sq;
   logic [9:0]           ax;
   logic [19:0]          g256_in, t106_in, t618_in;

   logic [20:0]          mag2;
   logic                 edge_hit;
   logic [6:0]           dir_char;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign p2_free   = !p2_valid_ff || out_free;
   assign p1_free   = !p1_valid_ff || p2_free;
   assign win_ready = p1_free;
   assign pop       = win_valid && p1_free;

   always_comb begin
      k = win_data;
      if (out_row_ff == '0) begin
         k[0] = '0;
      end
      gx_pos = 12'(k[0][2]) + {3'b0, k[1][2], 1'b0} + 12'(k[2][2]);
      gx_neg = 12'(k[0][0]) + {3'b0, k[1][0], 1'b0} + 12'(k[2][0]);
      gy_pos = 12'(k[2][0]) + {3'b0, k[2][1], 1'b0} + 12'(k[2][2]);
      gy_neg = 12'(k[0][0]) + {3'b0, k[0][1], 1'b0} + 12'(k[0][2]);
      gx_w   = gx_pos - gx_neg;
      gy_w   = gy_pos - gy_neg;
      gx_in  = signed'(gx_w[10:0]);
      gy_in  = signed'(gy_w[10:0]);
   end

   assign eor = out_col_ff == w_last;
   assign eof = eor && (out_row_ff == cfg.h_last);

   always_comb begin
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (cfg.restart) begin
         out_col_in = '0;
         out_row_in = '0;
      end else if (pop) begin
         if (eor) begin
            out_col_in = '0;
            out_row_in = eof ? 16'd0 : out_row_ff + 16'd1;
         end else begin
            out_col_in = out_col_ff + COL_W'(1);
         end
      end
   end

   always_comb begin
      gx_ext  = 12'(p1_gx_ff);
      gy_ext  = 12'(p1_gy_ff);
      flip    = (p1_gy_ff < 0) || ((p1_gy_ff == 0) && (p1_gx_ff < 0));
      gx_n    = flip ? -gx_ext : gx_ext;
      gy_n    = flip ? -gy_ext : gy_ext;
      ax_w    = gx_n[11] ? -gx_n : gx_n;
      ax      = ax_w[9:0];
      g256_in = {2'b0, gy_n[9:0], 8'd0};
      t106_in = 20'(ax) * seam_pkg::TAN_LO;
      t618_in = 20'(ax) * seam_pkg::TAN_HI;
      gx_sq   = p1_gx_ff * p1_gx_ff;
      gy_sq   = p1_gy_ff * p1_gy_ff;
   end

   always_comb begin
      mag2     = 21'(p2_gx2_ff) + 21'(p2_gy2_ff);
      edge_hit = cfg.edges_en && (22'(mag2) >= cfg.thr2);
      if (p2_zero_ff) begin
         dir_char = seam_pkg::CHAR_VERT;
      end else if (!p2_neg_ff) begin
         if (p2_g256_ff < p2_t106_ff) begin
            dir_char = seam_pkg::CHAR_VERT;
         end else if (p2_g256_ff < p2_t618_ff) begin
            dir_char = seam_pkg::CHAR_BACK;
         end else begin
            dir_char = seam_pkg::CHAR_FLAT;
         end
      end else begin
         if (p2_g256_ff > p2_t618_ff) begin
            dir_char = seam_pkg::CHAR_FLAT;
         end else if (p2_g256_ff > p2_t106_ff) begin
            dir_char = seam_pkg::CHAR_FWD;
         end else begin
            dir_char = seam_pkg::CHAR_VERT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         if (p1_free) begin
            p1_valid_ff <= win_valid;
         end
         if (p2_free) begin
            p2_valid_ff <= p1_valid_ff;
         end
         if (out_free) begin
            rsp_valid_ff <= p2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         p1_gx_ff  <= gx_in;
         p1_gy_ff  <= gy_in;
         p1_lum_ff <= seam_pkg::lum_char(win_data[1][1]);
         p1_eor_ff <= eor;
         p1_eof_ff <= eof;
      end
      if (p2_free && p1_valid_ff) begin
         p2_gx2_ff  <= gx_sq[19:0];
         p2_gy2_ff  <= gy_sq[19:0];
         p2_g256_ff <= g256_in;
         p2_t106_ff <= t106_in;
         p2_t618_ff <= t618_in;
         p2_neg_ff  <= gx_n[11];
         p2_zero_ff <= (p1_gx_ff == 0) && (p1_gy_ff == 0);
         p2_lum_ff  <= p1_lum_ff;
         p2_eor_ff  <= p1_eor_ff;
         p2_eof_ff  <= p1_eof_ff;
      end
      if (out_free && p2_valid_ff) begin
         rsp_char_ff <= edge_hit ? dir_char : p2_lum_ff;
         rsp_edge_ff <= edge_hit;
         rsp_eor_ff  <= p2_eor_ff;
         rsp_eof_ff  <= p2_eof_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_char     = rsp_char_ff;
   assign rsp_is_edge      = rsp_edge_ff;
   assign rsp_end_of_row   = rsp_eor_ff;
   assign rsp_end_of_frame = rsp_eof_ff;

endmodule

// ----- hdl/sobel_edge_ascii_mapper_top.sv -----
// Top level of the Sobel edge ASCII mapper: register file, front, queue and back.
// Depends on seam_pkg, seam_front, seam_queue and seam_back.
//
// Pixels enter in raster order on the req_ channel, one beat per pixel; a beat
// with req_op set is a drain beat. Each character leaves on the rsp_ channel
// one row plus one pixel behind the pixel stream, so after the last pixel of
// a frame the source sends image_width+1 drain beats to flush the last row.
// A character passes the front stage, the window queue and three back stages.
// The block takes one beat per cycle: each line store is read and written once
// per beat at the current column, and the window arithmetic is spread over
// three register stages. When rsp_ready is low the result register, the back
// stages and a four-entry window queue fill in turn before req_ready drops.
// Reset sets the registers to their defaults (width 640, height 480, threshold
// 350, edges enabled) and returns all position counters to the start of a
// frame; the line stores are not cleared, as the top image row is always taken
// with a zero row above it. Writing width or height restarts the frame. The user
// must write registers through the APB-style port while idle; it is not enforced.
module sobel_edge_ascii_mapper_top #(
   parameter int MAX_WIDTH   = seam_pkg::MAX_WIDTH_DEF,
   parameter int QUEUE_DEPTH = seam_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_op,
   input  logic [7:0]                      req_red,
   input  logic [7:0]                      req_green,
   input  logic [7:0]                      req_blue,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [6:0]                      rsp_out_char,
   output logic                            rsp_is_edge,
   output logic                            rsp_end_of_row,
   output logic                            rsp_end_of_frame,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [seam_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [seam_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [seam_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int WID_W = $clog2(MAX_WIDTH + 1);
   localparam int CW    = (WID_W > 11) ? WID_W : 11;

   logic [10:0]                   img_w_ff, img_w_in;
   logic [15:0]                   img_h_ff, img_h_in;
   logic [10:0]                   thr_ff, thr_in;
   logic                          edges_en_ff, edges_en_in;
   logic [COL_W-1:0]              w_last_ff;
   logic [15:0]                   h_last_ff;
   logic [seam_pkg::THR_SQ_W-1:0] thr2_ff;

   logic                          csr_write;
   logic                          restart;
   seam_pkg::reg_index_type       csr_index;
   seam_pkg::cfg_type             cfg;
   logic                          win_valid_f, win_ready_f;
   seam_pkg::window_type          win_data_f;
   logic                          win_valid_b, win_ready_b;
   logic [$bits(seam_pkg::window_type)-1:0] win_data_b;

   function automatic logic [COL_W-1:0] width_last(input logic [10:0] w);
      logic [CW-1:0] wx;
      wx = CW'(w);
      if (wx < CW'(seam_pkg::MIN_WIDTH)) begin
         wx = CW'(seam_pkg::MIN_WIDTH);
      end else if (wx > CW'(MAX_WIDTH)) begin
         wx = CW'(MAX_WIDTH);
      end
      wx = wx - CW'(1);
      return wx[COL_W-1:0];
   endfunction

   function automatic logic [15:0] height_last(input logic [15:0] h);
      return (h == 16'd0) ? 16'd0 : h - 16'd1;
   endfunction

   function automatic logic [seam_pkg::THR_SQ_W-1:0] thr_square(input logic [10:0] t);
      return seam_pkg::THR_SQ_W'(t) * seam_pkg::THR_SQ_W'(t);
   endfunction

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = seam_pkg::reg_index_type'(paddr[3:2]);

   always_comb begin
      img_w_in    = img_w_ff;
      img_h_in    = img_h_ff;
      thr_in      = thr_ff;
      edges_en_in = edges_en_ff;
      restart     = 1'b0;
      if (csr_write) begin
         case (csr_index)
            seam_pkg::REG_IMAGE_WIDTH: begin
               img_w_in = pwdata[10:0];
               restart  = 1'b1;
            end
            seam_pkg::REG_IMAGE_HEIGHT: begin
               img_h_in = pwdata[15:0];
               restart  = 1'b1;
            end
            seam_pkg::REG_EDGE_THRESHOLD: begin
               thr_in = pwdata[10:0];
            end
            seam_pkg::REG_EDGES_ENABLED: begin
               edges_en_in = pwdata[0];
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         seam_pkg::REG_IMAGE_WIDTH:    prdata = seam_pkg::CSR_DATA_W'(img_w_ff);
         seam_pkg::REG_IMAGE_HEIGHT:   prdata = seam_pkg::CSR_DATA_W'(img_h_ff);
         seam_pkg::REG_EDGE_THRESHOLD: prdata = seam_pkg::CSR_DATA_W'(thr_ff);
         seam_pkg::REG_EDGES_ENABLED:  prdata = seam_pkg::CSR_DATA_W'(edges_en_ff);
         default:                      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         img_w_ff    <= seam_pkg::IMAGE_WIDTH_RST;
         img_h_ff    <= seam_pkg::IMAGE_HEIGHT_RST;
         thr_ff      <= seam_pkg::EDGE_THRESHOLD_RST;
         edges_en_ff <= seam_pkg::EDGES_ENABLED_RST;
         w_last_ff   <= width_last(seam_pkg::IMAGE_WIDTH_RST);
         h_last_ff   <= height_last(seam_pkg::IMAGE_HEIGHT_RST);
         thr2_ff     <= thr_square(seam_pkg::EDGE_THRESHOLD_RST);
      end else begin
         img_w_ff    <= img_w_in;
         img_h_ff    <= img_h_in;
         thr_ff      <= thr_in;
         edges_en_ff <= edges_en_in;
         w_last_ff   <= width_last(img_w_in);
         h_last_ff   <= height_last(img_h_in);
         thr2_ff     <= thr_square(thr_in);
      end
   end

   assign cfg.restart  = restart;
   assign cfg.h_last   = h_last_ff;
   assign cfg.thr2     = thr2_ff;
   assign cfg.edges_en = edges_en_ff;

   seam_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .w_last    (w_last_ff),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_op),
      .req_red   (req_red),
      .req_green (req_green),
      .req_blue  (req_blue),
      .win_valid (win_valid_f),
      .win_ready (win_ready_f),
      .win_data  (win_data_f)
   );

   seam_queue #(
      .WIDTH ($bits(seam_pkg::window_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (win_valid_f),
      .push_ready (win_ready_f),
      .push_data  (win_data_f),
      .pop_valid  (win_valid_b),
      .pop_ready  (win_ready_b),
      .pop_data   (win_data_b)
   );

   seam_back #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .w_last           (w_last_ff),
      .win_valid        (win_valid_b),
      .win_ready        (win_ready_b),
      .win_data         (seam_pkg::window_type'(win_data_b)),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_char     (rsp_out_char),
      .rsp_is_edge      (rsp_is_edge),
      .rsp_end_of_row   (rsp_end_of_row),
      .rsp_end_of_frame (rsp_end_of_frame)
   );

endmodule
